// ===== rtl/core/rosq_pkg.sv =====
// Package for the random order service queue.
// Holds the field widths, request codes, state type and cell control struct.
// No dependencies.
package rosq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int RAND_BITS_DEF   = 16;

    localparam int ID_W    = 8;
    localparam int WORK_W  = 32;
    localparam int TIME_W  = 48;
    localparam int TOTAL_W = 36;

    localparam logic REQ_ARRIVAL  = 1'b0;
    localparam logic REQ_COMPLETE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL,
        ST_PICK,
        ST_SEL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/rosq_if.sv =====
// Valid/ready channel interfaces for the random order service queue.
// Depends on rosq_pkg for the field widths.
interface rosq_in_if #(
    parameter int RAND_W = rosq_pkg::RAND_BITS_DEF
);
    import rosq_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [ID_W-1:0]     req_id;
    logic [WORK_W-1:0]   work;
    logic [TIME_W-1:0]   now;
    logic [RAND_W-1:0]   rand_value;

    modport source (
        output valid, req_type, req_id, work, now, rand_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, req_id, work, now, rand_value,
        output ready
    );
endinterface

interface rosq_out_if #(
    parameter int LEN_W = $clog2(rosq_pkg::QUEUE_DEPTH_DEF + 1)
);
    import rosq_pkg::*;

    logic                valid;
    logic                ready;
    logic                started;
    logic [ID_W-1:0]     started_id;
    logic [TIME_W-1:0]   finish_time;
    logic [ID_W-1:0]     done_id;
    logic                dropped;
    logic [LEN_W-1:0]    queue_length;
    logic [TOTAL_W-1:0]  work_left;

    modport source (
        output valid, started, started_id, finish_time, done_id, dropped,
               queue_length, work_left,
        input  ready
    );
    modport sink (
        input  valid, started, started_id, finish_time, done_id, dropped,
               queue_length, work_left,
        output ready
    );
endinterface

// ===== rtl/core/rosq_cell.sv =====
// One storage cell of the queue chain: holds an id and its work size.
// Loads a new entry or takes its upper neighbor's entry when the queue compacts.
// Depends on rosq_pkg.
module rosq_cell (
    input  logic                         i_clk,
    input  rosq_pkg::t_cell_ctrl         i_ctrl,
    input  logic [rosq_pkg::ID_W-1:0]    i_new_id,
    input  logic [rosq_pkg::WORK_W-1:0]  i_new_work,
    input  logic [rosq_pkg::ID_W-1:0]    i_next_id,
    input  logic [rosq_pkg::WORK_W-1:0]  i_next_work,
    output logic [rosq_pkg::ID_W-1:0]    o_id,
    output logic [rosq_pkg::WORK_W-1:0]  o_work
);
    import rosq_pkg::*;

    logic [ID_W-1:0]   r_id;
    logic [WORK_W-1:0] r_work;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_id   <= i_new_id;
            r_work <= i_new_work;
        end else if (i_ctrl.shift) begin
            r_id   <= i_next_id;
            r_work <= i_next_work;
        end
    end

    assign o_id   = r_id;
    assign o_work = r_work;

endmodule

// ===== rtl/core/rosq_pick.sv =====
// Random pick unit: registers rand_value times the entry count, then turns the
// product into the smallest index whose fraction covers the random value.
// Depends on rosq_pkg.
module rosq_pick #(
    parameter int QUEUE_DEPTH = rosq_pkg::QUEUE_DEPTH_DEF,
    parameter int RAND_BITS   = rosq_pkg::RAND_BITS_DEF,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [RAND_BITS-1:0] i_rand,
    input  logic [LEN_W-1:0]     i_count,
    output logic [IDX_W-1:0]     o_index
);
    import rosq_pkg::*;

    localparam int PROD_W = RAND_BITS + LEN_W;

    logic [PROD_W-1:0] r_prod;
    logic [LEN_W:0]    w_ceil;
    logic [LEN_W:0]    w_idx;
    logic [LEN_W:0]    w_last;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_rand) * PROD_W'(i_count);
        end
    end

    always_comb begin
        w_ceil = (LEN_W + 1)'(r_prod[PROD_W-1:RAND_BITS])
               + (LEN_W + 1)'(|r_prod[RAND_BITS-1:0]);
        w_idx  = (w_ceil == '0) ? '0 : w_ceil - (LEN_W + 1)'(1);
        w_last = (LEN_W + 1)'(i_count) - (LEN_W + 1)'(1);
        if (w_idx > w_last) begin
            w_idx = w_last;
        end
        o_index = w_idx[IDX_W-1:0];
    end

endmodule

// ===== rtl/core/random_order_service_queue.sv =====
// Random order service queue: one result word per event word. A sequencer walks
// one event through the cell chain and the pick unit in the steps update,
// multiply, pick, select and finish; a new event word is taken only once the
// previous one has finished and its result has been registered for output.
// Reset clears the entry count, serving index, start time, work sum and the
// output valid; cell contents stay undefined until written.
module random_order_service_queue #(
    parameter int QUEUE_DEPTH = rosq_pkg::QUEUE_DEPTH_DEF,
    parameter int RAND_BITS   = rosq_pkg::RAND_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rosq_in_if.sink           i_req,
    rosq_out_if.source        o_res
);
    import rosq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

    t_state r_state;
    t_state n_state;

    logic                 r_type;
    logic [ID_W-1:0]      r_id;
    logic [WORK_W-1:0]    r_work;
    logic [TIME_W-1:0]    r_now;
    logic [RAND_BITS-1:0] r_rand;

    logic [LEN_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_serving;
    logic [TIME_W-1:0]    r_service_start;
    logic [TOTAL_W-1:0]   r_total;

    logic                 r_started;
    logic                 r_dropped;
    logic [ID_W-1:0]      r_done_id;
    logic [ID_W-1:0]      r_sel_id;
    logic [WORK_W-1:0]    r_sel_work;
    logic [TIME_W-1:0]    r_elapsed;

    logic                 r_out_valid;
    logic                 r_o_started;
    logic [ID_W-1:0]      r_o_started_id;
    logic [TIME_W-1:0]    r_o_finish;
    logic [ID_W-1:0]      r_o_done_id;
    logic                 r_o_dropped;
    logic [LEN_W-1:0]     r_o_length;
    logic [TOTAL_W-1:0]   r_o_work_left;

    logic w_accept;
    logic w_upd_en;
    logic w_mul_en;
    logic w_pick_en;
    logic w_sel_en;
    logic w_fin_en;
    logic w_out_free;

    logic [ID_W-1:0]    w_ids   [QUEUE_DEPTH];
    logic [WORK_W-1:0]  w_works [QUEUE_DEPTH];
    t_cell_ctrl         w_ctrl  [QUEUE_DEPTH];

    logic [IDX_W-1:0]   w_victim;
    logic [IDX_W-1:0]   w_sel_addr;
    logic [ID_W-1:0]    w_rd_id;
    logic [WORK_W-1:0]  w_rd_work;
    logic [IDX_W-1:0]   w_pick_idx;
    logic               w_full;
    logic [TOTAL_W-1:0] w_work_left;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_accept   = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_req.valid) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_MUL;
            ST_MUL:    n_state = ST_PICK;
            ST_PICK:   n_state = ST_SEL;
            ST_SEL:    n_state = ST_FIN;
            ST_FIN:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        w_upd_en    = 1'b0;
        w_mul_en    = 1'b0;
        w_pick_en   = 1'b0;
        w_sel_en    = 1'b0;
        w_fin_en    = 1'b0;
        unique case (r_state)
            ST_IDLE:   i_req.ready = 1'b1;
            ST_UPDATE: w_upd_en    = 1'b1;
            ST_MUL:    w_mul_en    = 1'b1;
            ST_PICK:   w_pick_en   = 1'b1;
            ST_SEL:    w_sel_en    = 1'b1;
            ST_FIN:    w_fin_en    = w_out_free;
            default:   i_req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type <= i_req.req_type;
            r_id   <= i_req.req_id;
            r_work <= i_req.work;
            r_now  <= i_req.now;
            r_rand <= i_req.rand_value;
        end
    end

    // The entry in service; a stale index falls back to the last entry.
    always_comb begin
        w_full = (r_count == LEN_W'(QUEUE_DEPTH));
        if (LEN_W'(r_serving) >= r_count) begin
            w_victim = IDX_W'(r_count - LEN_W'(1));
        end else begin
            w_victim = r_serving;
        end
        w_sel_addr = w_upd_en ? w_victim : r_serving;
        w_rd_id    = w_ids[w_sel_addr];
        w_rd_work  = w_works[w_sel_addr];
    end

    for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
        logic [ID_W-1:0]   w_next_id;
        logic [WORK_W-1:0] w_next_work;

        if (j == QUEUE_DEPTH - 1) begin : g_top
            assign w_next_id   = '0;
            assign w_next_work = '0;
        end else begin : g_mid
            assign w_next_id   = w_ids[j+1];
            assign w_next_work = w_works[j+1];
        end

        always_comb begin
            w_ctrl[j].load  = w_upd_en && (r_type == REQ_ARRIVAL) && !w_full
                              && (r_count == LEN_W'(j));
            w_ctrl[j].shift = w_upd_en && (r_type == REQ_COMPLETE)
                              && (r_count != '0)
                              && (LEN_W'(j) >= LEN_W'(w_victim))
                              && (LEN_W'(j + 1) < r_count);
        end

        rosq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl[j]),
            .i_new_id    (r_id),
            .i_new_work  (r_work),
            .i_next_id   (w_next_id),
            .i_next_work (w_next_work),
            .o_id        (w_ids[j]),
            .o_work      (w_works[j])
        );
    end

    rosq_pick #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .RAND_BITS   (RAND_BITS)
    ) u_pick (
        .i_clk   (i_clk),
        .i_en    (w_mul_en),
        .i_rand  (r_rand),
        .i_count (r_count),
        .o_index (w_pick_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_serving       <= '0;
            r_service_start <= '0;
            r_total         <= '0;
        end else if (w_upd_en) begin
            if (r_type == REQ_ARRIVAL) begin
                if (!w_full) begin
                    r_count <= r_count + LEN_W'(1);
                    r_total <= r_total + TOTAL_W'(r_work);
                    if (r_count == '0) begin
                        r_serving       <= '0;
                        r_service_start <= r_now;
                    end
                end
            end else if (r_count != '0) begin
                r_count <= r_count - LEN_W'(1);
                r_total <= r_total - TOTAL_W'(w_rd_work);
                if (r_count != LEN_W'(1)) begin
                    r_service_start <= r_now;
                end
            end
        end else if (w_pick_en && r_started && (r_type == REQ_COMPLETE)) begin
            r_serving <= w_pick_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_en) begin
            r_started <= 1'b0;
            r_dropped <= 1'b0;
            r_done_id <= '0;
            if (r_type == REQ_ARRIVAL) begin
                r_dropped <= w_full;
                r_started <= (r_count == '0);
            end else if (r_count != '0) begin
                r_done_id <= w_rd_id;
                r_started <= (r_count != LEN_W'(1));
            end
        end
        if (w_sel_en) begin
            r_sel_id   <= w_rd_id;
            r_sel_work <= w_rd_work;
            r_elapsed  <= r_now - r_service_start;
        end
    end

    always_comb begin
        if (r_elapsed >= TIME_W'(r_total)) begin
            w_work_left = '0;
        end else begin
            w_work_left = r_total - r_elapsed[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_en) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_en) begin
            r_o_started    <= r_started;
            r_o_started_id <= r_started ? r_sel_id : '0;
            r_o_finish     <= r_started ? (r_now + TIME_W'(r_sel_work)) : '0;
            r_o_done_id    <= r_done_id;
            r_o_dropped    <= r_dropped;
            r_o_length     <= r_count;
            r_o_work_left  <= w_work_left;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.started      = r_o_started;
    assign o_res.started_id   = r_o_started_id;
    assign o_res.finish_time  = r_o_finish;
    assign o_res.done_id      = r_o_done_id;
    assign o_res.dropped      = r_o_dropped;
    assign o_res.queue_length = r_o_length;
    assign o_res.work_left    = r_o_work_left;

endmodule

// ===== test/rosq_checker.sv =====
// Checker for the random order service queue: watches the event and result channels,
// keeps its own copy of the queue state and compares every result word field by field.
// Depends on rosq_pkg and the channel interfaces in rosq_if.sv.
`timescale 1ns / 100ps

module rosq_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rosq_in_if   i_req,
    rosq_out_if  i_res,
    output int   o_fail_count,
    output int   o_result_count
);
    import rosq_pkg::*;

    localparam int LEN_W = $clog2(QUEUE_DEPTH_DEF + 1);

    typedef struct {
        logic               started;
        logic [ID_W-1:0]    started_id;
        logic [TIME_W-1:0]  finish_time;
        logic [ID_W-1:0]    done_id;
        logic               dropped;
        logic [LEN_W-1:0]   queue_length;
        logic [TOTAL_W-1:0] work_left;
    } t_outcome;

    logic [ID_W-1:0]    held_id   [QUEUE_DEPTH_DEF];
    logic [WORK_W-1:0]  held_work [QUEUE_DEPTH_DEF];
    int                 held_count;
    int                 serve_idx;
    logic [TIME_W-1:0]  serve_start;
    logic [TOTAL_W-1:0] work_sum;

    t_outcome outcome_q [$];
    int       mismatches = 0;
    int       results    = 0;

    task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : event_monitor
        t_outcome          pred;
        t_outcome          want;
        int                k;
        int                j;
        logic [63:0]       prod;
        logic [63:0]       scale;
        logic [63:0]       ceil_q;
        logic [TIME_W-1:0] elapsed;

        if (!i_rst_n) begin
            held_count  = 0;
            serve_idx   = 0;
            serve_start = '0;
            work_sum    = '0;
            outcome_q.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                pred = '{default: '0};
                if (i_req.req_type == REQ_ARRIVAL) begin
                    if (held_count >= QUEUE_DEPTH_DEF) begin
                        pred.dropped = 1'b1;
                    end else begin
                        held_id[held_count]   = i_req.req_id;
                        held_work[held_count] = i_req.work;
                        held_count++;
                        work_sum = work_sum + TOTAL_W'(i_req.work);
                        if (held_count == 1) begin
                            serve_idx        = 0;
                            serve_start      = i_req.now;
                            pred.started     = 1'b1;
                            pred.started_id  = i_req.req_id;
                            pred.finish_time = i_req.now + TIME_W'(i_req.work);
                        end
                    end
                end else if (held_count > 0) begin
                    k = (serve_idx >= held_count) ? held_count - 1 : serve_idx;
                    pred.done_id = held_id[k];
                    work_sum = work_sum - TOTAL_W'(held_work[k]);
                    for (j = k; j + 1 < held_count; j++) begin
                        held_id[j]   = held_id[j + 1];
                        held_work[j] = held_work[j + 1];
                    end
                    held_count--;
                    if (held_count > 0) begin
                        prod   = 64'(i_req.rand_value) * 64'(held_count);
                        scale  = 64'd1 << RAND_BITS_DEF;
                        ceil_q = (prod + scale - 64'd1) / scale;
                        k = (ceil_q == 0) ? 0 : int'(ceil_q - 64'd1);
                        if (k > held_count - 1) begin
                            k = held_count - 1;
                        end
                        serve_idx        = k;
                        serve_start      = i_req.now;
                        pred.started     = 1'b1;
                        pred.started_id  = held_id[k];
                        pred.finish_time = i_req.now + TIME_W'(held_work[k]);
                    end
                end
                pred.queue_length = LEN_W'(held_count);
                elapsed = i_req.now - serve_start;
                if (TIME_W'(work_sum) <= elapsed) begin
                    pred.work_left = '0;
                end else begin
                    pred.work_left = work_sum - elapsed[TOTAL_W-1:0];
                end
                outcome_q.push_back(pred);
            end

            if (i_res.valid && i_res.ready) begin
                results++;
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word expected none, actual started_id %0h done_id %0h",
                             $time, i_res.started_id, i_res.done_id);
                end else begin
                    want = outcome_q.pop_front();
                    compare_field("started", TIME_W'(want.started),
                                  TIME_W'(i_res.started));
                    compare_field("started_id", TIME_W'(want.started_id),
                                  TIME_W'(i_res.started_id));
                    compare_field("finish_time", want.finish_time, i_res.finish_time);
                    compare_field("done_id", TIME_W'(want.done_id),
                                  TIME_W'(i_res.done_id));
                    compare_field("dropped", TIME_W'(want.dropped),
                                  TIME_W'(i_res.dropped));
                    compare_field("queue_length", TIME_W'(want.queue_length),
                                  TIME_W'(i_res.queue_length));
                    compare_field("work_left", TIME_W'(want.work_left),
                                  TIME_W'(i_res.work_left));
                end
            end
        end
        o_fail_count   <= mismatches;
        o_result_count <= results;
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the random order service queue testbench: clock, reset, event stimulus and
// result back-pressure, with the verdict taken from the checker module beside the block.
// Depends on rosq_pkg, rosq_if.sv, the block and rosq_checker.sv.
`timescale 1ns / 100ps

module tb_top;
    import rosq_pkg::*;

    localparam int RX_HOLD_CYCLES = 150;
    localparam int MAX_GAP        = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rosq_in_if  req_bus ();
    rosq_out_if res_bus ();

    int fail_count;
    int result_count;
    int words_sent   = 0;
    int arrivals     = 0;
    int completions  = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_asked   = 0;
    int hold_done    = 0;
    logic [TIME_W-1:0] sim_ticks;

    always #6 i_clk = ~i_clk;

    random_order_service_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    rosq_checker i_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_bus),
        .i_res          (res_bus),
        .o_fail_count   (fail_count),
        .o_result_count (result_count)
    );

    task automatic push_word(input logic kind, input logic [ID_W-1:0] id,
                             input logic [WORK_W-1:0] work, input logic [TIME_W-1:0] at,
                             input logic [RAND_BITS_DEF-1:0] frac);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.req_id     <= id;
        req_bus.work       <= work;
        req_bus.now        <= at;
        req_bus.rand_value <= frac;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        words_sent++;
        if (kind == REQ_ARRIVAL) begin
            arrivals++;
        end else begin
            completions++;
        end
    endtask

    task automatic random_burst(input int count);
        int                       arrive_pct;
        logic                     kind;
        logic [WORK_W-1:0]        work;
        logic [RAND_BITS_DEF-1:0] frac;
        arrive_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: arrive_pct = 25;
                    1: arrive_pct = 50;
                    default: arrive_pct = 80;
                endcase
            end
            if ($urandom_range(99) < 5) begin
                sim_ticks = TIME_W'({$urandom, $urandom});
            end else begin
                sim_ticks = sim_ticks + TIME_W'($urandom_range(300));
            end
            work = ($urandom_range(99) < 70) ? $urandom_range(2000) : $urandom;
            case ($urandom_range(9))
                0: frac = '0;
                1: frac = '1;
                default: frac = RAND_BITS_DEF'($urandom);
            endcase
            kind = ($urandom_range(99) < arrive_pct) ? REQ_ARRIVAL : REQ_COMPLETE;
            push_word(kind, ID_W'($urandom_range(255)), work, sim_ticks, frac);
        end
    endtask

    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_done != hold_asked) begin
                res_bus.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_ARRIVAL;
        req_bus.req_id     <= '0;
        req_bus.work       <= '0;
        req_bus.now        <= '0;
        req_bus.rand_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 29;
        rx_idle_pct = 54;

        // Completion on an empty queue, then the queue is filled past full.
        push_word(REQ_COMPLETE, 8'hFF, 32'hFFFF_FFFF, '0, '1);
        push_word(REQ_ARRIVAL, 8'h00, 32'h0, '0, '0);
        push_word(REQ_ARRIVAL, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, '1);
        for (int i = 2; i < QUEUE_DEPTH_DEF; i++) begin
            push_word(REQ_ARRIVAL, ID_W'(i * 17), WORK_W'(i * 1000), TIME_W'(100 + i), '0);
        end
        push_word(REQ_ARRIVAL, 8'hAA, 32'h1234, 48'd150, '0);
        push_word(REQ_COMPLETE, 8'h00, 32'h0, 48'd200, '0);
        push_word(REQ_COMPLETE, 8'h00, 32'h0, 48'd300, '1);
        push_word(REQ_COMPLETE, 8'h00, 32'h0, 48'hFFFF_FFFF_FFF0, 16'h8000);
        push_word(REQ_COMPLETE, 8'h00, 32'h0, 48'd5, 16'h0001);
        push_word(REQ_ARRIVAL, 8'h5A, 32'hFFFF_FFFF, 48'd6, '0);

        sim_ticks = 48'd10;
        random_burst(150);
        // The receiver stops for a long stretch while words keep coming.
        hold_asked <= hold_asked + 1;
        random_burst(170);
        req_bus.valid <= 1'b0;
        wait (result_count == words_sent);

        tx_idle_pct = 54;
        rx_idle_pct = 29;
        random_burst(315);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_burst(315);

        req_bus.valid <= 1'b0;
        wait (result_count == words_sent);
        repeat (20) @(posedge i_clk);

        $display("Run drove %0d event words (%0d arrivals, %0d completions)",
                 words_sent, arrivals, completions);
        $display("and compared %0d results through full and empty queues, drops, %s",
                 result_count, "wrapped times and stalls on both sides.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
